// ----- hw/rtl/pgq_pkg.sv -----
// Shared types, constants and helper functions for the per-group int8 quantizer.
// Has no dependencies; every other file imports it.
`timescale 1ns / 1ps
package pgq_pkg;

    // Widths that the interface fixes.
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int EXP_W      = 10;

    // Element encodings.
    localparam logic [1:0] FMT_F32  = 2'd0;
    localparam logic [1:0] FMT_BF16 = 2'd1;
    localparam logic [1:0] FMT_F16  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GROUP  = 2'd1;

    // Float32 constants.
    localparam logic [31:0] FLT_EXP_MASK = 32'h7F80_0000;
    localparam logic [31:0] SCALE_FLOOR  = 32'h0DA2_4260;  // 1.0e-30f
    localparam logic [31:0] DIVISOR_127  = 32'h42FE_0000;  // 127.0f

    // Descriptor of one complete group waiting in the queue.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic [30:0]      absmax;
    } t_grp_desc;

    // Write into the element buffer.
    typedef struct packed {
        logic        en;
        logic        bank;
        logic [5:0]  idx;
        logic [31:0] data;
    } t_mem_wr;

    // Quotient of the shared divider: mantissa with hidden bit, unbiased exponent.
    typedef struct packed {
        logic [23:0]             mant;
        logic signed [EXP_W-1:0] expo;
    } t_div_res;

    typedef enum logic [1:0] {
        D_IDLE,
        D_NORM,
        D_DIV,
        D_RND
    } t_div_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCALE_WAIT,
        B_READ,
        B_LOAD,
        B_DIV_WAIT,
        B_EMIT
    } t_back_state;

    // Widen a half-precision value to float32 bits.
    function automatic logic [31:0] f_half_to_single(logic [15:0] h);
        logic       sgn;
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] pos;
        logic [3:0] s;
        logic [9:0] frac;
        logic [7:0] e8;
        sgn  = h[15];
        e    = h[14:10];
        m    = h[9:0];
        pos  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                pos = 4'(i);
            end
        end
        s    = 4'd10 - pos;
        frac = m << s;
        e8   = 8'd113 - {4'd0, s};
        if (e == 5'd0) begin
            if (m == 10'd0) begin
                return {sgn, 31'd0};
            end
            return {sgn, e8, frac, 13'd0};
        end
        if (e == 5'h1F) begin
            return {sgn, 8'hFF, m, 13'd0};
        end
        return {sgn, 8'({3'd0, e} + 8'd112), m, 13'd0};
    endfunction

    // Widen a raw element to float32 bits according to the format code.
    function automatic logic [31:0] f_widen(logic [1:0] fmt, logic [31:0] raw);
        logic [31:0] w;
        case (fmt)
            FMT_BF16: w = {raw[15:0], 16'd0};
            FMT_F16:  w = f_half_to_single(raw[15:0]);
            default:  w = raw;
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/pgq_front.sv -----
// Front part: widens incoming elements, writes them to the group buffer and
// tracks the finite absmax. Depends on pgq_pkg.
`timescale 1ns / 1ps
module pgq_front #(
    parameter int MAX_GROUP = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [31:0]                   i_element_bits,
    input  logic [1:0]                    i_input_format,
    input  logic [pgq_pkg::CNT_W-1:0]     i_group_size,
    input  logic                          i_q_full,
    output logic                          o_push,
    output pgq_pkg::t_grp_desc            o_desc,
    output pgq_pkg::t_mem_wr              o_mem_wr
);
    import pgq_pkg::*;

    logic             r_bank;
    logic [CNT_W-1:0] r_fill;
    logic [30:0]      r_absmax;

    logic             accept;
    logic [31:0]      w;
    logic             finite;
    logic [30:0]      new_abs;
    logic [CNT_W-1:0] gs;
    logic [CNT_W-1:0] fill_next;
    logic             close;

    // A transfer is taken whenever a bank is free to fill.
    assign accept = i_valid && !i_q_full;

    // Widen the element and fold it into the running absmax.
    always_comb begin
        w       = f_widen(i_input_format, i_element_bits);
        finite  = (w & FLT_EXP_MASK) != FLT_EXP_MASK;
        new_abs = (finite && (w[30:0] > r_absmax)) ? w[30:0] : r_absmax;
        if (i_group_size == '0) begin
            gs = CNT_W'(1);
        end else if (i_group_size > CNT_W'(MAX_GROUP)) begin
            gs = CNT_W'(MAX_GROUP);
        end else begin
            gs = i_group_size;
        end
        fill_next = r_fill + CNT_W'(1);
        close     = fill_next >= gs;
    end

    // Buffer write and group descriptor.
    always_comb begin
        o_mem_wr.en   = accept;
        o_mem_wr.bank = r_bank;
        o_mem_wr.idx  = r_fill[5:0];
        o_mem_wr.data = w;
        o_push        = accept && close;
        o_desc.bank   = r_bank;
        o_desc.count  = fill_next;
        o_desc.absmax = new_abs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank   <= 1'b0;
            r_fill   <= '0;
            r_absmax <= '0;
        end else if (accept) begin
            if (close) begin
                r_bank   <= !r_bank;
                r_fill   <= '0;
                r_absmax <= '0;
            end else begin
                r_fill   <= fill_next;
                r_absmax <= new_abs;
            end
        end
    end

endmodule

// ----- hw/rtl/pgq_queue.sv -----
// Two-entry queue of complete group descriptors between front and back.
// Depends on pgq_pkg.
`timescale 1ns / 1ps
module pgq_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pgq_pkg::t_grp_desc i_desc,
    input  logic               i_pop,
    output pgq_pkg::t_grp_desc o_head,
    output logic               o_full,
    output logic               o_empty
);
    import pgq_pkg::*;

    t_grp_desc  r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_head  = r_entry[r_rd_ptr];
    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- hw/rtl/pgq_fdiv.sv -----
// Bit-serial float32 magnitude divider with round-to-nearest-even.
// Depends on pgq_pkg. The divisor must be a normal number.
`timescale 1ns / 1ps
module pgq_fdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [30:0]       i_a,
    input  logic [30:0]       i_b,
    output logic              o_done,
    output pgq_pkg::t_div_res o_res
);
    import pgq_pkg::*;

    t_div_state              r_state;
    t_div_state              n_state;
    logic [23:0]             r_ma;
    logic [23:0]             r_mb;
    logic signed [EXP_W-1:0] r_e;
    logic [24:0]             r_rem;
    logic [25:0]             r_q;
    logic [4:0]              r_cnt;

    logic                    ge;
    logic [24:0]             diff;
    logic signed [EXP_W-1:0] ea;
    logic signed [EXP_W-1:0] eb;
    logic [23:0]             m;
    logic                    g;
    logic                    s;
    logic signed [EXP_W-1:0] x;
    logic [24:0]             m_up;

    // Unpack operands; a subnormal dividend is normalized later.
    always_comb begin
        ea = (i_a[30:23] != 8'd0)
            ? $signed({2'b00, i_a[30:23]}) - EXP_W'(127) : -EXP_W'(126);
        eb = $signed({2'b00, i_b[30:23]}) - EXP_W'(127);
    end

    // One quotient bit per cycle.
    always_comb begin
        ge   = r_rem >= {1'b0, r_mb};
        diff = ge ? r_rem - {1'b0, r_mb} : r_rem;
    end

    // Normalize the 26-bit quotient and round to 24 bits.
    always_comb begin
        if (r_q[25]) begin
            m = r_q[25:2];
            g = r_q[1];
            s = r_q[0] | (|r_rem);
            x = r_e;
        end else begin
            m = r_q[24:1];
            g = r_q[0];
            s = |r_rem;
            x = r_e - EXP_W'(1);
        end
        m_up = {1'b0, m} + 25'(g & (s | m[0]));
        if (m_up[24]) begin
            o_res.mant = 24'h80_0000;
            o_res.expo = x + EXP_W'(1);
        end else begin
            o_res.mant = m_up[23:0];
            o_res.expo = x;
        end
    end

    assign o_done = r_state == D_RND;

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE:  if (i_start) n_state = D_NORM;
            D_NORM:  if (r_ma[23]) n_state = D_DIV;
            D_DIV:   if (r_cnt == 5'd0) n_state = D_RND;
            D_RND:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                r_ma <= {(i_a[30:23] != 8'd0), i_a[22:0]};
                r_mb <= {1'b1, i_b[22:0]};
                r_e  <= ea - eb;
            end
            D_NORM: begin
                if (r_ma[23]) begin
                    r_rem <= {1'b0, r_ma};
                    r_q   <= '0;
                    r_cnt <= 5'd25;
                end else begin
                    r_ma <= {r_ma[22:0], 1'b0};
                    r_e  <= r_e - EXP_W'(1);
                end
            end
            D_DIV: begin
                r_rem <= {diff[23:0], 1'b0};
                r_q   <= {r_q[24:0], ge};
                r_cnt <= r_cnt - 5'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/pgq_back.sv -----
// Back part: holds the group buffer, computes the scale and quantizes each
// buffered element through one shared divider. Depends on pgq_pkg, pgq_fdiv.
`timescale 1ns / 1ps
module pgq_back #(
    parameter int MAX_GROUP = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pgq_pkg::t_mem_wr   i_mem_wr,
    input  pgq_pkg::t_grp_desc i_head,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [7:0]  o_quant_value,
    output logic [31:0]        o_group_scale,
    output logic [5:0]         o_element_index,
    output logic               o_last_of_group
);
    import pgq_pkg::*;

    localparam int IDX_W = $clog2(MAX_GROUP);
    localparam int DEPTH = 2 ** (IDX_W + 1);

    logic [31:0]       r_mem [DEPTH];
    logic [31:0]       r_rd_data;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [31:0]       r_scale;
    logic [CNT_W-1:0]  r_k;
    logic signed [7:0] r_q;
    logic              r_neg;
    logic              r_out_valid;

    logic              div_start;
    logic [30:0]       div_a;
    logic [30:0]       div_b;
    logic              div_done;
    t_div_res          div_res;
    logic [IDX_W:0]    rd_addr;
    logic              e_skip;
    logic              is_last;
    logic              emit;
    logic [31:0]       scale_bits;
    logic signed [7:0] q_val;

    // Convert a rounded quotient to an int8 with half-to-even and clamp.
    function automatic logic signed [7:0] f_to_int8(t_div_res r, logic neg);
        logic [47:0] t;
        logic [5:0]  sh;
        logic [8:0]  iv;
        logic [7:0]  mag;
        t   = '0;
        sh  = '0;
        iv  = '0;
        mag = '0;
        if (r.expo < -EXP_W'(1)) begin
            mag = 8'd0;
        end else if (r.expo > EXP_W'(6)) begin
            mag = 8'd127;
        end else begin
            sh  = 6'(EXP_W'(23) - r.expo);
            t   = {r.mant, 24'd0} >> sh;
            iv  = t[32:24] + 9'(t[23] & ((|t[22:0]) | t[24]));
            mag = (iv > 9'd127) ? 8'd127 : iv[7:0];
        end
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // Group buffer: written by the front, read here with a registered port.
    assign rd_addr = {i_head.bank, r_k[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[{i_mem_wr.bank, i_mem_wr.idx[IDX_W-1:0]}] <= i_mem_wr.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    pgq_fdiv u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_b     (div_b),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    // Scale from the quotient absmax / 127, floored at 1e-30.
    always_comb begin
        logic signed [EXP_W-1:0] be;
        be         = div_res.expo + EXP_W'(127);
        scale_bits = {1'b0, be[7:0], div_res.mant[22:0]};
        if (be < EXP_W'(1) || scale_bits < SCALE_FLOOR) begin
            scale_bits = SCALE_FLOOR;
        end
    end

    assign q_val   = f_to_int8(div_res, r_neg);
    assign e_skip  = ((r_rd_data & FLT_EXP_MASK) == FLT_EXP_MASK) || (r_rd_data[30:0] == '0);
    assign is_last = (r_k + CNT_W'(1)) == i_head.count;
    assign emit    = (r_state == B_EMIT) && (!r_out_valid || !i_stall);
    assign o_pop   = emit && is_last;

    // Sequencer: next state and divider requests.
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_a     = i_head.absmax;
        div_b     = DIVISOR_127[30:0];
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    if (i_head.absmax == '0) begin
                        n_state = B_READ;
                    end else begin
                        div_start = 1'b1;
                        n_state   = B_SCALE_WAIT;
                    end
                end
            end
            B_SCALE_WAIT: if (div_done) n_state = B_READ;
            B_READ:       n_state = B_LOAD;
            B_LOAD: begin
                div_a = r_rd_data[30:0];
                div_b = r_scale[30:0];
                if (e_skip) begin
                    n_state = B_EMIT;
                end else begin
                    div_start = 1'b1;
                    n_state   = B_DIV_WAIT;
                end
            end
            B_DIV_WAIT:   if (div_done) n_state = B_EMIT;
            B_EMIT: begin
                if (emit) begin
                    n_state = is_last ? B_IDLE : B_READ;
                end
            end
            default:      n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Per-group and per-element working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    r_k     <= '0;
                    r_scale <= SCALE_FLOOR;
                end
                B_SCALE_WAIT: if (div_done) r_scale <= scale_bits;
                B_LOAD: begin
                    r_neg <= r_rd_data[31];
                    r_q   <= '0;
                end
                B_DIV_WAIT:   if (div_done) r_q <= q_val;
                B_EMIT:       if (emit && !is_last) r_k <= r_k + CNT_W'(1);
                default: begin
                end
            endcase
        end
    end

    // Output register: refilled when empty or when its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_quant_value   <= r_q;
            o_group_scale   <= r_scale;
            o_element_index <= 6'(r_k);
            o_last_of_group <= is_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- hw/rtl/per_group_absmax_int8_quantizer.sv -----
// Per-group absmax int8 quantizer, top level. Depends on pgq_pkg and its submodules.
// Throughput: one element per cycle into a free buffer bank; results come one at a time
// from the shared divider (one serial quotient bit per cycle), which also computes each
// group's scale first. Synchronous active-low reset clears control state and
// configuration (format float32, group size 64).
`timescale 1ns / 1ps
module per_group_absmax_int8_quantizer #(
    parameter int MAX_GROUP = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [31:0]                     i_element_bits,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [7:0]               o_quant_value,
    output logic [31:0]                     o_group_scale,
    output logic [5:0]                      o_element_index,
    output logic                            o_last_of_group,
    input  logic                            i_cfg_we,
    input  logic [pgq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pgq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pgq_pkg::*;

    logic [1:0]       r_input_format;
    logic [CNT_W-1:0] r_group_size;

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    t_grp_desc        desc;
    t_grp_desc        head;
    t_mem_wr          mem_wr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_format <= FMT_F32;
            r_group_size   <= CNT_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_FORMAT: r_input_format <= i_cfg_data[1:0];
                CFG_IDX_GROUP:  r_group_size   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_stall = q_full;

    pgq_front #(.MAX_GROUP(MAX_GROUP)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_element_bits (i_element_bits),
        .i_input_format (r_input_format),
        .i_group_size   (r_group_size),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_desc         (desc),
        .o_mem_wr       (mem_wr)
    );

    pgq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pgq_back #(.MAX_GROUP(MAX_GROUP)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mem_wr        (mem_wr),
        .i_head          (head),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_quant_value   (o_quant_value),
        .o_group_scale   (o_group_scale),
        .o_element_index (o_element_index),
        .o_last_of_group (o_last_of_group)
    );

    // A completed group never arrives while both banks are occupied.
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("group pushed into a full queue");

    // The back part only retires a group that is queued.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("group retired from an empty queue");

    // Buffer writes stay inside one group.
    a_wr_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr.en |-> (32'(mem_wr.idx) < 32'(MAX_GROUP)))
        else $error("buffer write beyond the group size");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the per-group absmax int8 quantizer.
// Depends on pgq_pkg and per_group_absmax_int8_quantizer from the RTL.
// A scoreboard class predicts every result bit for bit; plain tasks drive both ports.
`timescale 1ns / 1ps
module testbench;
    import pgq_pkg::*;

    localparam int MAX_GROUP    = 64;
    localparam int DRAIN_CYCLES = 150;
    localparam int STALL_LIMIT  = 20000;

    // Register indexes beyond the defined ones; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;
    localparam logic [1:0]           FMT_SPARE      = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [31:0]            i_element_bits = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic signed [7:0]      o_quant_value;
    logic [31:0]            o_group_scale;
    logic [5:0]             o_element_index;
    logic                   o_last_of_group;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    bit quiet = 1'b0;
    int idle_cycles = 0;

    typedef struct {
        logic signed [7:0] quant;
        logic [31:0]       scale;
        logic [5:0]        index;
        logic              last;
    } quant_result_t;

    // Divide two positive float magnitudes (b normal), correctly rounded.
    // Returns the 24-bit mantissa with hidden bit and the unbiased exponent.
    function automatic void fp_divide(input logic [30:0] a, input logic [30:0] b,
                                      output logic [23:0] mant, output int expo);
        int               ea, eb, sh;
        longint unsigned  ma, mb, q, r, m25;
        bit               guard, sticky;
        ea = int'(a[30:23]);
        ma = longint'(a[22:0]);
        if (ea == 0) begin
            ea = 1;
            while (((ma >> 23) & 1) == 0) begin
                ma = ma << 1;
                ea--;
            end
        end else begin
            ma = ma | (64'd1 << 23);
        end
        eb = int'(b[30:23]);
        mb = longint'(b[22:0]) | (64'd1 << 23);
        q = (ma << 26) / mb;
        r = (ma << 26) % mb;
        expo = ea - eb;
        if (q >= (64'd1 << 26)) begin
            sh = 3;
        end else begin
            sh = 2;
            expo = expo - 1;
        end
        m25 = q >> sh;
        guard = ((q >> (sh - 1)) & 1) != 0;
        sticky = ((q & ((64'd1 << (sh - 1)) - 1)) != 0) || (r != 0);
        if (guard && (sticky || m25[0])) begin
            m25 = m25 + 1;
        end
        if (m25 >= (64'd1 << 24)) begin
            m25 = m25 >> 1;
            expo = expo + 1;
        end
        mant = m25[23:0];
    endfunction

    // Widen half-precision bits to float32 bits.
    function automatic logic [31:0] half_to_f32(logic [15:0] h);
        logic [31:0] sgn;
        int          ex;
        logic [10:0] m;
        sgn = {h[15], 31'd0};
        ex = int'(h[14:10]);
        m = {1'b0, h[9:0]};
        if (ex == 0) begin
            if (m == 0) begin
                return sgn;
            end
            ex = 113;
            while (m[10] == 1'b0) begin
                m = m << 1;
                ex--;
            end
            return sgn | {1'b0, 8'(ex), m[9:0], 13'd0};
        end
        if (ex == 31) begin
            return sgn | FLT_EXP_MASK | {9'd0, m[9:0], 13'd0};
        end
        return sgn | {1'b0, 8'(ex + 112), m[9:0], 13'd0};
    endfunction

    function automatic bit is_finite(logic [31:0] w);
        return (w & FLT_EXP_MASK) != FLT_EXP_MASK;
    endfunction

    // Round half to even of w / scale, clamped to [-127, 127]; zero for non-finite.
    function automatic logic signed [7:0] quantize(logic [31:0] w, logic [31:0] scale);
        logic [23:0]     mant;
        int              expo;
        longint unsigned fx, t, fr;
        int              mag;
        if (!is_finite(w) || w[30:0] == 0) begin
            return 8'sd0;
        end
        fp_divide(w[30:0], scale[30:0], mant, expo);
        if (expo >= 8) begin
            mag = 127;
        end else if (expo < -4) begin
            mag = 0;
        end else begin
            fx = longint'(mant) << (expo + 9);
            t = fx >> 32;
            fr = fx & 64'hFFFF_FFFF;
            if (fr > 64'h8000_0000 || (fr == 64'h8000_0000 && t[0])) begin
                t = t + 1;
            end
            mag = (t > 127) ? 127 : int'(t);
        end
        return w[31] ? 8'(-mag) : 8'(mag);
    endfunction

    // Scale = max(absmax / 127, 1e-30) as float32 bits.
    function automatic logic [31:0] group_scale_of(logic [31:0] absmax);
        logic [23:0] mant;
        int          expo;
        logic [31:0] bits;
        if (absmax[30:23] == 0) begin
            return SCALE_FLOOR;
        end
        fp_divide(absmax[30:0], DIVISOR_127[30:0], mant, expo);
        if (expo + 127 <= 0) begin
            return SCALE_FLOOR;
        end
        bits = {1'b0, 8'(expo + 127), mant[22:0]};
        return (bits < SCALE_FLOOR) ? SCALE_FLOOR : bits;
    endfunction

    // Scoreboard: mirrors the group buffer and holds the results still to come.
    class quant_scoreboard;
        logic [1:0]    fmt;
        logic [6:0]    gsize;
        logic [31:0]   store[MAX_GROUP];
        int            fill;
        logic [31:0]   absmax;
        quant_result_t pending[$];
        int            errors;

        function new();
            fmt = FMT_F32;
            gsize = 7'd64;
            fill = 0;
            absmax = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_IDX_FORMAT) begin
                fmt = data[1:0];
            end else if (idx == CFG_IDX_GROUP) begin
                gsize = data;
            end
        endfunction

        // Record an accepted element; a completed group queues its results.
        function void note_element(logic [31:0] raw);
            logic [31:0]   w, scale;
            int            gs, n;
            quant_result_t res;
            case (fmt)
                FMT_BF16: w = {raw[15:0], 16'd0};
                FMT_F16:  w = half_to_f32(raw[15:0]);
                default:  w = raw;
            endcase
            gs = int'(gsize);
            if (gs == 0) gs = 1;
            if (gs > MAX_GROUP) gs = MAX_GROUP;
            if (fill >= MAX_GROUP) fill = MAX_GROUP - 1;
            store[fill] = w;
            fill++;
            if (is_finite(w) && {1'b0, w[30:0]} > absmax) begin
                absmax = {1'b0, w[30:0]};
            end
            if (fill < gs) return;
            scale = group_scale_of(absmax);
            n = fill;
            for (int k = 0; k < n; k++) begin
                res.quant = quantize(store[k], scale);
                res.scale = scale;
                res.index = 6'(k);
                res.last  = (k + 1 == n);
                pending.push_back(res);
            end
            fill = 0;
            absmax = '0;
        endfunction

        function void check_result(logic signed [7:0] q, logic [31:0] s,
                                   logic [5:0] idx, logic last);
            quant_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result q=%0d scale=%h idx=%0d last=%0b",
                         $realtime, q, s, idx, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (q !== e.quant) begin
                $display("%0t: quant_value expected %0d actual %0d", $realtime, e.quant, q);
                errors++;
            end
            if (s !== e.scale) begin
                $display("%0t: group_scale expected %h actual %h", $realtime, e.scale, s);
                errors++;
            end
            if (idx !== e.index) begin
                $display("%0t: element_index expected %0d actual %0d", $realtime, e.index, idx);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last_of_group expected %0b actual %0b", $realtime, e.last, last);
                errors++;
            end
        endfunction
    endclass

    quant_scoreboard sb = new();

    per_group_absmax_int8_quantizer #(.MAX_GROUP(MAX_GROUP)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_element_bits(i_element_bits),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_quant_value(o_quant_value), .o_group_scale(o_group_scale),
        .o_element_index(o_element_index), .o_last_of_group(o_last_of_group),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Result side: random stall, and every result transfer is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_quant_value, o_group_scale, o_element_index, o_last_of_group);
        end
        i_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end

    // Count cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one element, with a random idle gap first, and hold it until taken.
    task automatic send_element(logic [31:0] bits);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_element_bits <= bits;
        do @(posedge i_clk); while (o_stall);
        sb.note_element(bits);
    endtask

    // Stop sending and wait until every expected result has come, then let
    // the block finish any work that produces no result.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(logic [1:0] fmt, logic [6:0] gs);
        wait_drained();
        write_reg(CFG_IDX_FORMAT, {5'd0, fmt});
        write_reg(CFG_IDX_GROUP, gs);
    endtask

    // Random element for the given format, clustered near a base exponent
    // so that quantized values spread over the whole int8 range.
    function automatic logic [31:0] random_element(logic [1:0] fmt, int base);
        int          r, ex;
        logic [31:0] p;
        r = $urandom_range(0, 99);
        if (r < 12) return $urandom;
        if (fmt == FMT_F16) begin
            ex = (base % 31) - $urandom_range(0, 6);
            if (ex < 0) ex = 0;
            if (r < 16) ex = 31;
            return {$urandom_range(0, 65535) & 16'hFFFF, 1'($urandom), 5'(ex),
                    10'($urandom)};
        end
        ex = base - $urandom_range(0, 10);
        if (ex < 0) ex = 0;
        if (r < 16) ex = 255;
        p = {1'($urandom), 8'(ex), 23'($urandom)};
        if (fmt == FMT_BF16) return {16'($urandom), p[31:16]};
        return p;
    endfunction

    initial begin
        int          sent;
        int          gs_pick, gs, n, base;
        logic [1:0]  fmt;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Float32 extremes: zeros, largest finite, infinities, NaN, subnormal.
        set_config(FMT_F32, 7'd8);
        send_element(32'h0000_0000);
        send_element(32'h8000_0000);
        send_element(32'h7F7F_FFFF);
        send_element(32'hFF7F_FFFF);
        send_element(32'h7F80_0000);
        send_element(32'hFF80_0000);
        send_element(32'h7FC0_0001);
        send_element(32'h0000_0001);
        // Tiny group where the scale floor applies.
        set_config(FMT_F32, 7'd3);
        send_element(32'h1000_0000);
        send_element(32'h9000_0000);
        send_element(32'h0C00_0000);
        // Bfloat16 with garbage in the upper half.
        set_config(FMT_BF16, 7'd4);
        send_element(32'hFFFF_3F80);
        send_element(32'h1234_7F80);
        send_element(32'hABCD_FFC1);
        send_element(32'h0000_0001);
        // Half: subnormals, largest finite, infinity, NaN payload.
        set_config(FMT_F16, 7'd6);
        send_element(32'h0000_0001);
        send_element(32'h0000_83FF);
        send_element(32'h0000_7BFF);
        send_element(32'h0000_FC00);
        send_element(32'h0000_7E01);
        send_element(32'h0000_3C00);
        // Format code three acts as float32; group size zero acts as one.
        set_config(FMT_SPARE, 7'd0);
        send_element(32'h3F80_0000);
        send_element(32'hC2FE_0000);
        // Writes to unused indexes must change nothing.
        wait_drained();
        write_reg(CFG_IDX_SPARE2, 7'h7F);
        write_reg(CFG_IDX_SPARE3, 7'h55);
        // Format changed mid-group, then group size lowered mid-group.
        set_config(FMT_F16, 7'd64);
        send_element(32'h0000_4000);
        send_element(32'h0000_C500);
        set_config(FMT_BF16, 7'd64);
        send_element(32'h0000_4040);
        set_config(FMT_BF16, 7'd2);
        send_element(32'h0000_BF00);

        // Random phases with random configuration.
        sent = 0;
        for (int ph = 0; sent < 450; ph++) begin
            fmt = (ph % 9 == 4) ? FMT_SPARE : 2'($urandom_range(0, 2));
            gs_pick = $urandom_range(0, 99);
            if (ph == 1 || ph == 6) gs = 64;
            else if (ph == 2) gs = 1;
            else if (ph == 5) gs = 127;
            else if (gs_pick < 25) gs = $urandom_range(1, 4);
            else if (gs_pick < 75) gs = $urandom_range(5, 32);
            else if (gs_pick < 90) gs = 64;
            else if (gs_pick < 95) gs = 0;
            else gs = $urandom_range(65, 127);
            set_config(fmt, 7'(gs));
            quiet = (ph == 3);
            n = (gs == 0) ? 8 : ((gs > 64 ? 64 : gs) * $urandom_range(1, 2));
            if ($urandom_range(0, 3) == 0) n += $urandom_range(0, 5);
            base = $urandom_range(1, 254);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 15) == 0) base = $urandom_range(1, 254);
                send_element(random_element(fmt, base));
            end
            sent += n;
            quiet = 1'b0;
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (sb.pending.size() != 0) begin
                $display("%0t: %0d expected results never arrived",
                         $realtime, sb.pending.size());
            end
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
